/* rtl/core/block_frequency_health_test_core_defines.svh */
// ----------------------------------------------------------------------------
// block frequency health test assertion macros
// shared macros for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef BLOCK_FREQUENCY_HEALTH_TEST_CORE_DEFINES_SVH
`define BLOCK_FREQUENCY_HEALTH_TEST_CORE_DEFINES_SVH

// check that is off while reset is asserted
`define BFHT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// check that also runs through reset
`define BFHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bfht_pkg.sv */
// ----------------------------------------------------------------------------
// bfht_pkg
// widths, codes and types of the block frequency health test
// ----------------------------------------------------------------------------
package bfht_pkg;

  localparam int LEN_W   = 16;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 24;
  localparam int THR_W   = 48;
  localparam int MAG_W   = LEN_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int CFG_W   = 48;
  localparam int CFG_A_W = 1;

  localparam int IN_TDATA_W  = 8;
  localparam int RES_W       = 2 + SUM_W + CNT_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = PTR_W + 1;

  localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = LEN_W'(128);
  localparam logic [LEN_W-1:0] MIN_BLOCK_LENGTH = LEN_W'(2);

  typedef enum logic [CFG_A_W-1:0] {
    CFG_BLOCK_LENGTH   = 1'b0,
    CFG_FAIL_THRESHOLD = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_FAIL    = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [CNT_W-1:0] blocks_seen;
    logic [SUM_W-1:0] scaled_statistic;
    verdict_t         verdict;
  } result_t;

endpackage

/* rtl/core/bfht_result_fifo.sv */
// ----------------------------------------------------------------------------
// bfht_result_fifo
// small queue of finished results in front of the result channel
// ----------------------------------------------------------------------------
module bfht_result_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  bfht_pkg::result_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output bfht_pkg::result_t rd_data
);

  bfht_pkg::result_t                 mem [bfht_pkg::FIFO_DEPTH];
  logic [bfht_pkg::PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [bfht_pkg::PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [bfht_pkg::FCNT_W-1:0]       fill_r, fill_nxt;
  logic                              pop;

  assign rd_valid = (fill_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (wr_en && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!wr_en && pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/block_frequency_health_test_core.sv */
// ----------------------------------------------------------------------------
// block_frequency_health_test_core
// block frequency health test on a serial bit stream
// ----------------------------------------------------------------------------
// Takes one bit per cycle while in_tready is high, with tlast on the final
// bit of a sequence. Ones are counted in blocks of block_length bits; each
// finished block adds (2*ones - block_length)^2 to a saturating sum. The
// result for a sequence (verdict, sum, block count) passes stages 1 to 3
// into an eight-entry result queue; in_tready drops only when eight results
// are in flight or queued and not yet taken. Counters, accumulator and
// result credit are the per-cycle loops; the square of a block deviation
// sits in a 17x17 multiplier stage of its own, followed by the accumulate
// stage and a compare stage against fail_threshold. Write configuration
// only while no sequence is in progress and no result is pending.
module block_frequency_health_test_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfht_pkg::CFG_A_W-1:0]        cfg_addr,
  input  logic [bfht_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] bit_value, upper bits zero
  input  logic [bfht_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] verdict, [49:2] scaled_statistic, [73:50] blocks_seen, upper zero
  output logic [bfht_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // configuration
  logic [bfht_pkg::LEN_W-1:0] block_length_r;
  logic [bfht_pkg::THR_W-1:0] fail_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r   <= bfht_pkg::BLOCK_LENGTH_RST;
      fail_threshold_r <= '0;
    end else if (cfg_we) begin
      unique case (bfht_pkg::cfg_idx_t'(cfg_addr))
        bfht_pkg::CFG_BLOCK_LENGTH:   block_length_r   <= cfg_wdata[bfht_pkg::LEN_W-1:0];
        bfht_pkg::CFG_FAIL_THRESHOLD: fail_threshold_r <= cfg_wdata[bfht_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // result credit: results in flight plus results queued
  logic [bfht_pkg::FCNT_W-1:0] credit_r, credit_nxt;
  logic in_acc, out_acc, in_last_acc;

  assign in_tready   = (credit_r < bfht_pkg::FCNT_W'(bfht_pkg::FIFO_DEPTH));
  assign in_acc      = in_tvalid && in_tready;
  assign in_last_acc = in_acc && in_tlast;
  assign out_acc     = out_tvalid && out_tready;

  always_comb begin
    credit_nxt = credit_r;
    if (in_last_acc && !out_acc) begin
      credit_nxt = credit_r + 1'b1;
    end else if (!in_last_acc && out_acc) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  // stage 1: bit and ones counters, block deviation magnitude
  logic [bfht_pkg::LEN_W-1:0] bits_r, bits_nxt;
  logic [bfht_pkg::LEN_W-1:0] ones_r, ones_nxt;
  logic [bfht_pkg::LEN_W:0]   n_sum, ones_sum;
  logic [bfht_pkg::LEN_W+1:0] twice_ones, len_ext;
  logic [bfht_pkg::LEN_W+1:0] dev_abs;
  logic                       blk_done;

  logic                       s1_valid_r, s1_last_r, s1_done_r;
  logic [bfht_pkg::MAG_W-1:0] s1_mag_r;

  always_comb begin
    n_sum      = {1'b0, bits_r} + 1'b1;
    ones_sum   = {1'b0, ones_r} + {{bfht_pkg::LEN_W{1'b0}}, in_tdata[0]};
    blk_done   = (n_sum >= {1'b0, block_length_r});
    twice_ones = {ones_sum, 1'b0};
    len_ext    = {2'b00, block_length_r};
    dev_abs    = (twice_ones >= len_ext) ? twice_ones - len_ext : len_ext - twice_ones;
    bits_nxt   = bits_r;
    ones_nxt   = ones_r;
    if (in_acc) begin
      if (blk_done || in_tlast) begin
        bits_nxt = '0;
        ones_nxt = '0;
      end else begin
        bits_nxt = n_sum[bfht_pkg::LEN_W-1:0];
        ones_nxt = ones_sum[bfht_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r     <= '0;
      ones_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      bits_r     <= bits_nxt;
      ones_r     <= ones_nxt;
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= in_tlast;
    s1_done_r <= blk_done;
    s1_mag_r  <= dev_abs[bfht_pkg::MAG_W-1:0];
  end

  // stage 2: square of the deviation
  logic                      s2_valid_r, s2_last_r, s2_done_r;
  logic [bfht_pkg::SQ_W-1:0] s2_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_last_r <= s1_last_r;
    s2_done_r <= s1_done_r;
    s2_sq_r   <= s1_mag_r * s1_mag_r;
  end

  // stage 3: saturating accumulate, snapshot on the last bit
  logic [bfht_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_new;
  logic [bfht_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_new;
  logic [bfht_pkg::SUM_W:0]   sum_add;
  logic                       fin_valid_r;
  logic [bfht_pkg::SUM_W-1:0] fin_sum_r;
  logic [bfht_pkg::CNT_W-1:0] fin_cnt_r;

  always_comb begin
    sum_add = {1'b0, sum_r} + {{(bfht_pkg::SUM_W + 1 - bfht_pkg::SQ_W){1'b0}}, s2_sq_r};
    sum_new = sum_r;
    cnt_new = cnt_r;
    if (s2_done_r) begin
      sum_new = sum_add[bfht_pkg::SUM_W] ? '1 : sum_add[bfht_pkg::SUM_W-1:0];
      cnt_new = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
    end
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (s2_valid_r) begin
      sum_nxt = s2_last_r ? '0 : sum_new;
      cnt_nxt = s2_last_r ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      fin_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      fin_valid_r <= s2_valid_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    fin_sum_r <= sum_new;
    fin_cnt_r <= cnt_new;
  end

  // stage 4: verdict into the result queue
  bfht_pkg::result_t res_in, res_out;

  always_comb begin
    res_in.scaled_statistic = fin_sum_r;
    res_in.blocks_seen      = fin_cnt_r;
    if (fin_cnt_r == '0 || block_length_r < bfht_pkg::MIN_BLOCK_LENGTH) begin
      res_in.verdict = bfht_pkg::VERDICT_INVALID;
    end else if (fin_sum_r > fail_threshold_r) begin
      res_in.verdict = bfht_pkg::VERDICT_FAIL;
    end else begin
      res_in.verdict = bfht_pkg::VERDICT_PASS;
    end
  end

  bfht_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fin_valid_r),
    .wr_data  (res_in),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (res_out)
  );

  assign out_tdata = {{(bfht_pkg::OUT_TDATA_W - bfht_pkg::RES_W){1'b0}}, res_out};

endmodule

/* rtl/core/bfht_checker.sv */
// ----------------------------------------------------------------------------
// bfht_checker
// port-level checks of the block frequency health test core
// ----------------------------------------------------------------------------
`include "block_frequency_health_test_core_defines.svh"

module bfht_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bfht_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [1:0]                 res_verdict;
  logic [bfht_pkg::SUM_W-1:0] res_sum;
  logic [bfht_pkg::CNT_W-1:0] res_blocks;
  logic                       in_last_req;

  assign res_verdict = out_tdata[1:0];
  assign res_sum     = out_tdata[bfht_pkg::SUM_W+1:2];
  assign res_blocks  = out_tdata[bfht_pkg::RES_W-1:bfht_pkg::SUM_W+2];
  assign in_last_req = in_tvalid && in_tready && in_tlast;

  // a stalled result request holds its payload
  `BFHT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result request changed while stalled")

  // nothing is offered right after reset
  `BFHT_ASSERT_ALWAYS(a_out_after_reset, clk, !rst_n |=> !out_tvalid, "result offered after reset")

  // no complete block means invalid and an empty sum
  `BFHT_ASSERT(a_empty_invalid, clk, rst_n, out_tvalid && res_blocks == '0 |-> res_verdict == bfht_pkg::VERDICT_INVALID && res_sum == '0, "empty sequence not reported invalid")

  // the verdict is always one of the three defined codes
  `BFHT_ASSERT(a_verdict_code, clk, rst_n, out_tvalid |-> res_verdict == bfht_pkg::VERDICT_PASS || res_verdict == bfht_pkg::VERDICT_FAIL || res_verdict == bfht_pkg::VERDICT_INVALID, "undefined verdict code")

  // a result is offered only after an accepted last request
  `BFHT_ASSERT(a_no_early_result, clk, rst_n, !in_last_req ##1 !in_last_req ##1 !in_last_req ##1 !in_last_req ##1 !out_tvalid |=> !out_tvalid || $past(out_tvalid), "result appeared without a sequence end")

endmodule

bind block_frequency_health_test_core bfht_checker u_bfht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
